// ----- rtl/btk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and fixed field widths of the bounded top-k sorted list.
// ----------------------------------------------------------------------------
package btk_pkg;

  localparam int unsigned RMSD_W = 16;
  localparam int unsigned RIDX_W = 4;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned FILL_W = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

endpackage

// ----- rtl/btk_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btk_cell
// One list slot: holds an entry, ranks the incoming candidate against it and
// either keeps its entry, takes the candidate or takes its left neighbor.
// ----------------------------------------------------------------------------
module btk_cell #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned CNT_W = 8
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic                      occ_i,
  input  logic                      ins_left_i,
  input  logic [ID_W-1:0]           cand_id_i,
  input  logic [CNT_W-1:0]          cand_cnt_i,
  input  logic [btk_pkg::RMSD_W-1:0] cand_rmsd_i,
  input  logic [ID_W-1:0]           left_id_i,
  input  logic [CNT_W-1:0]          left_cnt_i,
  input  logic [btk_pkg::RMSD_W-1:0] left_rmsd_i,
  output logic [ID_W-1:0]           id_o,
  output logic [CNT_W-1:0]          cnt_o,
  output logic [btk_pkg::RMSD_W-1:0] rmsd_o,
  output logic                      ins_o
);
  import btk_pkg::*;

  logic [ID_W-1:0]   id_q, id_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RMSD_W-1:0] rmsd_q, rmsd_d;
  logic              better;

  // candidate ranks strictly above this entry
  assign better = (cand_cnt_i > cnt_q) ||
                  ((cand_cnt_i == cnt_q) && (cand_rmsd_i < rmsd_q));
  assign ins_o  = !occ_i || better;

  always_comb begin
    priority if (ins_left_i) begin
      id_d   = left_id_i;
      cnt_d  = left_cnt_i;
      rmsd_d = left_rmsd_i;
    end else if (ins_o) begin
      id_d   = cand_id_i;
      cnt_d  = cand_cnt_i;
      rmsd_d = cand_rmsd_i;
    end else begin
      id_d   = id_q;
      cnt_d  = cnt_q;
      rmsd_d = rmsd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      id_q   <= id_d;
      cnt_q  <= cnt_d;
      rmsd_q <= rmsd_d;
    end
  end

  assign id_o   = id_q;
  assign cnt_o  = cnt_q;
  assign rmsd_o = rmsd_q;

endmodule

// ----- rtl/bounded_top_k_sorted_list.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_top_k_sorted_list
// Keeps the best CAPACITY candidates ordered by match count, then Q8.8 RMSD.
// ----------------------------------------------------------------------------
// Every beat, insert or read, yields one registered result beat; a
// new beat is taken each cycle while the result register is free or being
// drained. The list lives in a row of cells, each ranking the candidate
// against its own entry in parallel; the cells at and after the insertion
// point shift right by one, so the last entry of a full list falls out. A
// read picks the entry at read_index through a mux over the cells.
module bounded_top_k_sorted_list #(
  parameter int unsigned CAPACITY    = 16,
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [COUNT_WIDTH-1:0]       match_count_i,
  input  logic [btk_pkg::RMSD_W-1:0]   rmsd_i,
  input  logic [ID_WIDTH-1:0]          item_id_i,
  input  logic [btk_pkg::RIDX_W-1:0]   read_index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         accepted_o,
  output logic [btk_pkg::POS_W-1:0]    position_o,
  output logic                         evicted_valid_o,
  output logic [ID_WIDTH-1:0]          evicted_id_o,
  output logic                         read_valid_o,
  output logic [ID_WIDTH-1:0]          read_id_o,
  output logic [COUNT_WIDTH-1:0]       read_count_o,
  output logic [btk_pkg::RMSD_W-1:0]   read_rmsd_o,
  output logic [btk_pkg::FILL_W-1:0]   fill_count_o
);
  import btk_pkg::*;

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = $clog2(CAPACITY);

  logic                    in_fire, is_ins, is_rd, full;
  logic [FW-1:0]           fill_q, fill_d;
  logic [CAPACITY-1:0]     ins;
  logic [ID_WIDTH-1:0]     cell_id   [CAPACITY];
  logic [COUNT_WIDTH-1:0]  cell_cnt  [CAPACITY];
  logic [RMSD_W-1:0]       cell_rmsd [CAPACITY];
  logic [PW-1:0]           pos;

  logic                    out_valid_q;
  logic                    acc_q, acc_d, ev_q, ev_d, rv_q, rv_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [ID_WIDTH-1:0]     evid_q, evid_d, rid_q, rid_d;
  logic [COUNT_WIDTH-1:0]  rcnt_q, rcnt_d;
  logic [RMSD_W-1:0]       rrmsd_q, rrmsd_d;
  logic [FILL_W-1:0]       fc_q, fc_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_rd      = (command_i == CMD_READ);
  assign is_ins     = !is_rd;
  assign full       = (fill_q == FW'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      btk_cell #(
        .ID_W  (ID_WIDTH),
        .CNT_W (COUNT_WIDTH)
      ) u_cell (
        .clk_i       (clk_i),
        .en_i        (in_fire && is_ins),
        .occ_i       (fill_q > FW'(i)),
        .ins_left_i  (1'b0),
        .cand_id_i   (item_id_i),
        .cand_cnt_i  (match_count_i),
        .cand_rmsd_i (rmsd_i),
        .left_id_i   (item_id_i),
        .left_cnt_i  (match_count_i),
        .left_rmsd_i (rmsd_i),
        .id_o        (cell_id[i]),
        .cnt_o       (cell_cnt[i]),
        .rmsd_o      (cell_rmsd[i]),
        .ins_o       (ins[i])
      );
    end else begin : g_body
      btk_cell #(
        .ID_W  (ID_WIDTH),
        .CNT_W (COUNT_WIDTH)
      ) u_cell (
        .clk_i       (clk_i),
        .en_i        (in_fire && is_ins),
        .occ_i       (fill_q > FW'(i)),
        .ins_left_i  (ins[i-1]),
        .cand_id_i   (item_id_i),
        .cand_cnt_i  (match_count_i),
        .cand_rmsd_i (rmsd_i),
        .left_id_i   (cell_id[i-1]),
        .left_cnt_i  (cell_cnt[i-1]),
        .left_rmsd_i (cell_rmsd[i-1]),
        .id_o        (cell_id[i]),
        .cnt_o       (cell_cnt[i]),
        .rmsd_o      (cell_rmsd[i]),
        .ins_o       (ins[i])
      );
    end
  end

  // insertion point: first cell whose ins flag rises
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins[i] && (i == 0 || !ins[(i == 0) ? 0 : i - 1])) begin
        pos = pos | PW'(i);
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (in_fire && is_ins && !full) begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_comb begin
    acc_d   = is_ins && ins[CAPACITY-1];
    pos_d   = acc_d ? POS_W'(pos) : '0;
    ev_d    = acc_d && full;
    evid_d  = ev_d ? cell_id[CAPACITY-1] : '0;
    rv_d    = is_rd && (FW'(read_index_i) < fill_q) && (FW >= RIDX_W || read_index_i < RIDX_W'(CAPACITY));
    rid_d   = '0;
    rcnt_d  = '0;
    rrmsd_d = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (rv_d && i < (1 << RIDX_W) && read_index_i == RIDX_W'(i)) begin
        rid_d   = cell_id[i];
        rcnt_d  = cell_cnt[i];
        rrmsd_d = cell_rmsd[i];
      end
    end
    fc_d = FILL_W'(fill_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      ev_q    <= ev_d;
      evid_q  <= evid_d;
      rv_q    <= rv_d;
      rid_q   <= rid_d;
      rcnt_q  <= rcnt_d;
      rrmsd_q <= rrmsd_d;
      fc_q    <= fc_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = acc_q;
  assign position_o      = pos_q;
  assign evicted_valid_o = ev_q;
  assign evicted_id_o    = evid_q;
  assign read_valid_o    = rv_q;
  assign read_id_o       = rid_q;
  assign read_count_o    = rcnt_q;
  assign read_rmsd_o     = rrmsd_q;
  assign fill_count_o    = fc_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(CAPACITY))
    else $error("fill count above capacity");

  a_fill_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_ins && !full) |=> (fill_q == $past(fill_q) + FW'(1)))
    else $error("insert into non-full list did not grow fill");

  a_read_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_rd) |=> $stable(fill_q))
    else $error("read beat changed fill");

  a_ins_thermo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins[CAPACITY-2:0] & ~ins[CAPACITY-1:1]) == '0)
    else $error("insertion flags not monotonic, list order broken");

  a_evict_acc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && evicted_valid_o) |-> (accepted_o && !read_valid_o))
    else $error("eviction without placement");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded top-k sorted list. A driver sends
// insert and read beats from a queue, in bursts with gaps. A monitor stalls
// the result channel on a changing pattern. Each accepted result is compared
// field by field with a shadow list kept in the bench. A short directed
// sequence covers empty reads, ties, drops and evictions. A random stream
// with rising match counts then keeps a full list churning.
// ----------------------------------------------------------------------------
module testbench;
  import btk_pkg::*;

  localparam int unsigned CAP       = 16;
  localparam int unsigned IDW       = 16;
  localparam int unsigned CNTW      = 8;
  localparam int unsigned N_RANDOM  = 700;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned TAIL      = 16;

  typedef struct packed {
    logic                 sync;
    cmd_e                 cmd;
    logic [CNTW-1:0]      cnt;
    logic [RMSD_W-1:0]    rmsd;
    logic [IDW-1:0]       id;
    logic [RIDX_W-1:0]    ridx;
  } list_req_t;

  typedef struct packed {
    logic                 acc;
    logic [POS_W-1:0]     pos;
    logic                 ev;
    logic [IDW-1:0]       ev_id;
    logic                 rv;
    logic [IDW-1:0]       rid;
    logic [CNTW-1:0]      rcnt;
    logic [RMSD_W-1:0]    rrmsd;
    logic [FILL_W-1:0]    fill;
  } list_rsp_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic                command_i     = 1'b0;
  logic [CNTW-1:0]     match_count_i = '0;
  logic [RMSD_W-1:0]   rmsd_i        = '0;
  logic [IDW-1:0]      item_id_i     = '0;
  logic [RIDX_W-1:0]   read_index_i  = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic                accepted_o;
  logic [POS_W-1:0]    position_o;
  logic                evicted_valid_o;
  logic [IDW-1:0]      evicted_id_o;
  logic                read_valid_o;
  logic [IDW-1:0]      read_id_o;
  logic [CNTW-1:0]     read_count_o;
  logic [RMSD_W-1:0]   read_rmsd_o;
  logic [FILL_W-1:0]   fill_count_o;

  bounded_top_k_sorted_list #(
    .CAPACITY    (CAP),
    .ID_WIDTH    (IDW),
    .COUNT_WIDTH (CNTW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .match_count_i   (match_count_i),
    .rmsd_i          (rmsd_i),
    .item_id_i       (item_id_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .accepted_o      (accepted_o),
    .position_o      (position_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_id_o    (evicted_id_o),
    .read_valid_o    (read_valid_o),
    .read_id_o       (read_id_o),
    .read_count_o    (read_count_o),
    .read_rmsd_o     (read_rmsd_o),
    .fill_count_o    (fill_count_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the ranked list
  logic [IDW-1:0]    shadow_ids   [CAP];
  logic [CNTW-1:0]   shadow_cnts  [CAP];
  logic [RMSD_W-1:0] shadow_rmsds [CAP];
  int unsigned       shadow_fill = 0;

  list_req_t candidate_q[$];
  list_rsp_t pending_outcomes[$];
  list_req_t cur_req;

  int unsigned errors      = 0;
  int unsigned cycles      = 0;
  int unsigned n_inserts   = 0;
  int unsigned n_placed    = 0;
  int unsigned n_evicted   = 0;
  int unsigned n_reads     = 0;
  int unsigned n_read_miss = 0;
  int unsigned n_results   = 0;

  function automatic list_rsp_t rank_and_update(list_req_t rq);
    list_rsp_t o;
    int unsigned pos;
    int unsigned top;
    bit found;
    bit place;
    o = '0;
    if (rq.cmd == CMD_INSERT) begin
      n_inserts++;
      pos = shadow_fill;
      found = 1'b0;
      place = 1'b1;
      top = 0;
      for (int unsigned i = 0; i < shadow_fill; i++) begin
        if (!found && ((rq.cnt > shadow_cnts[i]) ||
                       (rq.cnt == shadow_cnts[i] && rq.rmsd < shadow_rmsds[i]))) begin
          pos = i;
          found = 1'b1;
        end
      end
      if (shadow_fill < CAP) begin
        top = shadow_fill;
        shadow_fill++;
      end else if (pos < CAP) begin
        top = CAP - 1;
        o.ev = 1'b1;
        o.ev_id = shadow_ids[top];
        n_evicted++;
      end else begin
        place = 1'b0;
      end
      if (place) begin
        for (int unsigned i = top; i > pos; i--) begin
          shadow_ids[i]   = shadow_ids[i-1];
          shadow_cnts[i]  = shadow_cnts[i-1];
          shadow_rmsds[i] = shadow_rmsds[i-1];
        end
        shadow_ids[pos]   = rq.id;
        shadow_cnts[pos]  = rq.cnt;
        shadow_rmsds[pos] = rq.rmsd;
        o.acc = 1'b1;
        o.pos = pos[POS_W-1:0];
        n_placed++;
      end
    end else begin
      n_reads++;
      if (rq.ridx < shadow_fill) begin
        o.rv    = 1'b1;
        o.rid   = shadow_ids[rq.ridx];
        o.rcnt  = shadow_cnts[rq.ridx];
        o.rrmsd = shadow_rmsds[rq.ridx];
      end else begin
        n_read_miss++;
      end
    end
    o.fill = shadow_fill[FILL_W-1:0];
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (errors < 40)
        $display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  task automatic push_insert(logic [CNTW-1:0] c, logic [RMSD_W-1:0] r, logic [IDW-1:0] id);
    list_req_t rq;
    rq = '0;
    rq.cmd  = CMD_INSERT;
    rq.cnt  = c;
    rq.rmsd = r;
    rq.id   = id;
    rq.ridx = RIDX_W'($urandom);
    candidate_q.push_back(rq);
  endtask

  task automatic push_read(logic [RIDX_W-1:0] idx);
    list_req_t rq;
    rq = '0;
    rq.cmd  = CMD_READ;
    rq.cnt  = CNTW'($urandom);
    rq.rmsd = RMSD_W'($urandom);
    rq.id   = IDW'($urandom);
    rq.ridx = idx;
    candidate_q.push_back(rq);
  endtask

  task automatic push_sync();
    list_req_t rq;
    rq = '0;
    rq.sync = 1'b1;
    candidate_q.push_back(rq);
  endtask

  // driver: bursts of beats with random gaps, sync markers drain the block
  int burst_left = 8;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin : drive
      logic nv;
      nv = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        pending_outcomes.push_back(rank_and_update(cur_req));
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (candidate_q.size() > 0) begin
          if (candidate_q[0].sync) begin
            if (pending_outcomes.size() == 0) void'(candidate_q.pop_front());
          end else begin
            cur_req = candidate_q.pop_front();
            command_i     <= cur_req.cmd;
            match_count_i <= cur_req.cnt;
            rmsd_i        <= cur_req.rmsd;
            item_id_i     <= cur_req.id;
            read_index_i  <= cur_req.ridx;
            nv = 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 40);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end
        end
      end
      in_valid_i <= nv;
    end
  end

  // monitor: stall pattern is picked anew at random from four modes
  int unsigned stall_mode = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin : watch
      list_rsp_t e;
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result beat with nothing expected, fill_count 0x%0h",
                   $time, fill_count_o);
          errors++;
        end else begin
          e = pending_outcomes.pop_front();
          check_field("accepted",      e.acc,   accepted_o);
          check_field("position",      e.pos,   position_o);
          check_field("evicted_valid", e.ev,    evicted_valid_o);
          check_field("evicted_id",    e.ev_id, evicted_id_o);
          check_field("read_valid",    e.rv,    read_valid_o);
          check_field("read_id",       e.rid,   read_id_o);
          check_field("read_count",    e.rcnt,  read_count_o);
          check_field("read_rmsd",     e.rrmsd, read_rmsd_o);
          check_field("fill_count",    e.fill,  fill_count_o);
        end
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (cycles % 4 == 0);
        default: out_ready_i <= (cycles % 16 >= 12);
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycles, pending_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned base;
    int unsigned c;
    logic [RMSD_W-1:0] r;

    // directed: empty list, extremes and ties
    push_read(4'd0);
    push_read(4'd15);
    push_insert(8'd0,   16'hFFFF, 16'h0000);
    push_insert(8'd255, 16'h0000, 16'hFFFF);
    push_insert(8'd255, 16'h0000, 16'h0001);
    push_insert(8'd100, 16'h0100, 16'h0002);
    push_insert(8'd100, 16'h0080, 16'h0003);
    push_insert(8'd100, 16'h0100, 16'h0004);
    push_read(4'd0);
    push_read(4'd5);
    push_read(4'd6);
    for (int i = 0; i < 10; i++)
      push_insert(CNTW'(50 + 7 * i), RMSD_W'($urandom), IDW'(16'h0100 + i));
    // full list: equal to the last entry is dropped, a strong one evicts it
    push_insert(8'd0,   16'hFFFF, 16'h1234);
    push_insert(8'd255, 16'hFFFF, 16'hABCD);
    push_read(4'd15);
    push_read(4'd0);
    push_sync();

    // random: counts drift upward so new candidates keep displacing old ones
    for (int unsigned k = 0; k < N_RANDOM; k++) begin
      if (k == N_RANDOM / 3 || k == 2 * N_RANDOM / 3) push_sync();
      base = (k * 300) / N_RANDOM;
      if (base > 248) base = 248;
      case ($urandom_range(0, 9))
        0, 1: c = 0;
        2: c = $urandom_range(0, 255);
        3: c = $urandom_range(0, 1) ? 255 : 0;
        default: c = base + $urandom_range(0, 7);
      endcase
      case ($urandom_range(0, 9))
        0: r = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        1, 2, 3, 4: r = RMSD_W'(16'h0100 + 16'h0080 * $urandom_range(0, 3));
        default: r = RMSD_W'($urandom);
      endcase
      if (c == 0 && $urandom_range(0, 1) == 0)
        push_read(RIDX_W'($urandom_range(0, 15)));
      else if (c == 0)
        push_insert(CNTW'($urandom_range(0, 255)), r, IDW'($urandom));
      else
        push_insert(CNTW'(c), r, IDW'($urandom));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (candidate_q.size() != 0 || in_valid_i || pending_outcomes.size() != 0)
      @(negedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("ran %0d inserts (%0d placed, %0d evictions) and %0d reads (%0d past fill)",
             n_inserts, n_placed, n_evicted, n_reads, n_read_miss);
    $display("checked %0d result beats in %0d cycles", n_results, cycles);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- bounded_top_k_sorted_list.f -----
rtl/btk_pkg.sv
rtl/btk_cell.sv
rtl/bounded_top_k_sorted_list.sv
tb/testbench.sv
